// ===== rtl/core/slcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types, constants and the byte-wide CRC-32 step for the frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

	localparam int FRAME_LENGTH_BITS_DEF = 16;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC_FIRST  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC_SECOND = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_LENGTH  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LENGTH  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT     = 3'd4;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] MIN_LENGTH_RST  = 16'd4;
	localparam logic [15:0] MAX_LENGTH_RST  = 16'd1024;
	localparam logic [15:0] TIMEOUT_RST     = 16'd0;

	// frame status codes
	localparam logic [1:0] STATUS_GOOD    = 2'd0;
	localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
	localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] min_frame_length;
		logic [15:0] max_frame_length;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic [15:0] body_index;
		logic        body_valid;
		logic        frame_end;
		logic [1:0]  frame_status;
		logic [15:0] frame_length_out;
	} result_t;

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/slcfp_if.sv =====
// ----------------------------------------------------------------------------
// slcfp_if
// Valid/ready channels of the frame parser: item requests and result requests.
// ----------------------------------------------------------------------------
interface slcfp_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface slcfp_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  body_byte;
	logic [15:0] body_index;
	logic        body_valid;
	logic        frame_end;
	logic [1:0]  frame_status;
	logic [15:0] frame_length_out;

	modport source (output valid, output body_byte, output body_index, output body_valid,
		output frame_end, output frame_status, output frame_length_out, input ready);
	modport sink   (input valid, input body_byte, input body_index, input body_valid,
		input frame_end, input frame_status, input frame_length_out, output ready);
endinterface

// ===== rtl/core/sync_length_crc_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc_frame_parser
// Sync-hunting, length-prefixed byte deframer with CRC-32 frame check.
// ----------------------------------------------------------------------------
// Usage:
//  - item channel: one request per received byte (func 0) or per 1 ms tick
//    (func 1). Ticks never give a result.
//  - result channel: at most one request per item: a body byte with its
//    index, a frame close (last body byte, good or bad CRC), or an abort
//    (length out of range, timeout).
//  - cfg_we writes cfg_data to the register that cfg_index selects; write
//    only while the block is idle. Indexes above 4 are ignored.
// Timing:
//  - an accepted item is held in the input register, then the parser
//    logic (byte-wide CRC step, length and CRC compares) settles it into
//    the result register, from which the receiver takes it.
//  - throughput is one item per cycle while the receiver takes results.
// Reset: parser hunts for the first sync byte, CRC preset to all ones,
//  registers return to their defaults, both channel stages empty.
// Stall: a held result blocks the input stage only; one more item is still
//  taken into the input register, then item.ready drops until the result
//  is taken.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_parser #(
	parameter int FRAME_LENGTH_BITS = slcfp_pkg::FRAME_LENGTH_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slcfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [slcfp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	slcfp_item_if.sink                          item,
	slcfp_result_if.source                      result
);

	slcfp_pkg::cfg_t    cfg;
	slcfp_pkg::item_t   item_s1;
	logic               valid_s1;
	slcfp_pkg::result_t res;
	slcfp_pkg::result_t result_q;
	logic               res_valid_q;
	logic               emit;
	logic               step;

	slcfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the stage item moves on when the result slot is free or being emptied
	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;

	slcfp_parse_core #(
		.FRAME_LENGTH_BITS (FRAME_LENGTH_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.emit   (emit),
		.res    (res)
	);

	// control: stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) valid_s1 <= 1'b1;
			else if (step) valid_s1 <= 1'b0;
			if (step && emit) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.func      <= item.func;
			item_s1.data_byte <= item.data_byte;
		end
		if (step && emit) result_q <= res;
	end

	assign result.valid            = res_valid_q;
	assign result.body_byte        = result_q.body_byte;
	assign result.body_index       = result_q.body_index;
	assign result.body_valid       = result_q.body_valid;
	assign result.frame_end        = result_q.frame_end;
	assign result.frame_status     = result_q.frame_status;
	assign result.frame_length_out = result_q.frame_length_out;

endmodule

// ===== rtl/core/slcfp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slcfp_cfg_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module slcfp_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slcfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [slcfp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output slcfp_pkg::cfg_t                     cfg
);

	slcfp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first       <= slcfp_pkg::SYNC_FIRST_RST;
			cfg_q.sync_second      <= slcfp_pkg::SYNC_SECOND_RST;
			cfg_q.min_frame_length <= slcfp_pkg::MIN_LENGTH_RST;
			cfg_q.max_frame_length <= slcfp_pkg::MAX_LENGTH_RST;
			cfg_q.timeout_ticks    <= slcfp_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				slcfp_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first       <= cfg_data[7:0];
				slcfp_pkg::CFG_SYNC_SECOND: cfg_q.sync_second      <= cfg_data[7:0];
				slcfp_pkg::CFG_MIN_LENGTH:  cfg_q.min_frame_length <= cfg_data;
				slcfp_pkg::CFG_MAX_LENGTH:  cfg_q.max_frame_length <= cfg_data;
				slcfp_pkg::CFG_TIMEOUT:     cfg_q.timeout_ticks    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/slcfp_parse_core.sv =====
// ----------------------------------------------------------------------------
// slcfp_parse_core
// Deframer state and the single-pass next-state/result logic for one item.
// ----------------------------------------------------------------------------
module slcfp_parse_core #(
	parameter int FRAME_LENGTH_BITS = slcfp_pkg::FRAME_LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  slcfp_pkg::item_t     item,
	input  slcfp_pkg::cfg_t      cfg,
	output logic                 emit,
	output slcfp_pkg::result_t   res
);

	typedef enum logic [1:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	localparam logic [32:0] LEN_LIMIT = (33'd1 << FRAME_LENGTH_BITS) - 33'd1;

	phase_t      phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [31:0] lshift_q, lshift_d;
	logic [15:0] len_q, len_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] tail_q, tail_d;
	logic [15:0] ticks_q, ticks_d;

	logic [31:0] fl;
	logic [31:0] crc_upd;
	logic [31:0] tail_upd;
	logic [15:0] pos_inc;
	logic        len_bad;

	assign fl       = {item.data_byte, lshift_q[31:8]};
	assign tail_upd = {item.data_byte, tail_q[31:8]};
	assign crc_upd  = slcfp_pkg::crc_byte(crc_q, item.data_byte);
	assign pos_inc  = pos_q + 16'd1;
	assign len_bad  = (fl < 32'd4) || (fl < {16'd0, cfg.min_frame_length})
		|| (fl > {16'd0, cfg.max_frame_length}) || ({1'b0, fl} > LEN_LIMIT);

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		lshift_d = lshift_q;
		len_d    = len_q;
		crc_d    = crc_q;
		tail_d   = tail_q;
		ticks_d  = ticks_q;
		emit     = 1'b0;
		res      = '0;
		if (item.func) begin
			if (ticks_q != 16'hFFFF) ticks_d = ticks_q + 16'd1;
		end else begin
			case (phase_q)
				PH_SYNC1: begin
					if (item.data_byte == cfg.sync_first) phase_d = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (item.data_byte == cfg.sync_second) begin
						phase_d  = PH_LENGTH;
						pos_d    = 16'd0;
						lshift_d = 32'd0;
						crc_d    = slcfp_pkg::CRC_ALL_ONES;
					end else if (item.data_byte != cfg.sync_first) begin
						phase_d = PH_SYNC1;
					end
				end
				PH_LENGTH: begin
					lshift_d = fl;
					crc_d    = crc_upd;
					pos_d    = pos_inc;
					if (pos_inc >= 16'd4) begin
						if (len_bad) begin
							phase_d              = PH_SYNC1;
							emit                 = 1'b1;
							res.frame_end        = 1'b1;
							res.frame_status     = slcfp_pkg::STATUS_BAD_LEN;
							res.frame_length_out = (fl > 32'h0000_FFFF) ? 16'hFFFF : fl[15:0];
						end else begin
							len_d   = fl[15:0];
							pos_d   = 16'd0;
							tail_d  = 32'd0;
							ticks_d = 16'd0;
							phase_d = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					emit                 = 1'b1;
					res.frame_length_out = len_q;
					if ((cfg.timeout_ticks != 16'd0) && (ticks_q > cfg.timeout_ticks)) begin
						phase_d          = PH_SYNC1;
						res.frame_end    = 1'b1;
						res.frame_status = slcfp_pkg::STATUS_TIMEOUT;
					end else begin
						// last four body bytes are the received CRC
						if (pos_q < (len_q - 16'd4)) crc_d = crc_upd;
						else tail_d = tail_upd;
						pos_d          = pos_inc;
						res.body_byte  = item.data_byte;
						res.body_index = pos_q;
						res.body_valid = 1'b1;
						if (pos_inc == len_q) begin
							phase_d          = PH_SYNC1;
							res.frame_end    = 1'b1;
							res.frame_status = ((crc_q ^ slcfp_pkg::CRC_ALL_ONES) == tail_upd)
								? slcfp_pkg::STATUS_GOOD : slcfp_pkg::STATUS_BAD_CRC;
						end
					end
				end
				default: phase_d = PH_SYNC1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			pos_q    <= 16'd0;
			lshift_q <= 32'd0;
			len_q    <= 16'd0;
			crc_q    <= slcfp_pkg::CRC_ALL_ONES;
			tail_q   <= 32'd0;
			ticks_q  <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			lshift_q <= lshift_d;
			len_q    <= len_d;
			crc_q    <= crc_d;
			tail_q   <= tail_d;
			ticks_q  <= ticks_d;
		end
	end

endmodule
